// File: rtl/core/lnc_pkg.sv
// ----------------------------------------------------------------------------
// lnc_pkg
// Types and constants shared by the noise voice and its subtract unit.
// ----------------------------------------------------------------------------
package lnc_pkg;

    localparam int OP_W       = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_START_VOLUME    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_UP     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_PERIOD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SHIFT     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW_MODE     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR_CODE    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON        = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LOAD     = 8'd7;

    localparam logic [14:0] LFSR_SEED        = 15'h7FFF;
    localparam logic [23:0] LENGTH_LOAD_INIT = 24'h800000;
    localparam logic [3:0]  VOLUME_MAX       = 4'd15;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_ENV_ADD  = 7'b0000010,
        S_ENV_LOOP = 7'b0000100,
        S_LEN      = 7'b0001000,
        S_LFSR     = 7'b0010000,
        S_TAIL     = 7'b0100000,
        S_OUT      = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0] diff;
        logic            borrow;
        logic            zero;
    } sub_res_t;

    function automatic logic [6:0] divisor(input logic [2:0] code);
        logic [6:0] d;
        case (code)
            3'd0:    d = 7'd8;
            3'd1:    d = 7'd16;
            3'd2:    d = 7'd32;
            3'd3:    d = 7'd48;
            3'd4:    d = 7'd64;
            3'd5:    d = 7'd80;
            3'd6:    d = 7'd96;
            default: d = 7'd112;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/lnc_sub.sv
// ----------------------------------------------------------------------------
// lnc_sub
// Shared subtract and compare unit used by the envelope loop, length, lfsr and tail steps.
// ----------------------------------------------------------------------------
module lnc_sub
(
    input  logic [lnc_pkg::OP_W-1:0] a,
    input  logic [lnc_pkg::OP_W-1:0] b,
    output lnc_pkg::sub_res_t        res
);

    logic [lnc_pkg::OP_W:0] wide;

    assign wide       = {1'b0, a} - {1'b0, b};
    assign res.diff   = wide[lnc_pkg::OP_W-1:0];
    assign res.borrow = wide[lnc_pkg::OP_W];
    assign res.zero   = (wide[lnc_pkg::OP_W-1:0] == '0);

endmodule

// File: rtl/core/lfsr_noise_channel.sv
// sequence: a trigger beat goes from S_IDLE straight to S_OUT; an advance beat passes
// S_ENV_ADD and S_ENV_LOOP (one pass per envelope step) when the envelope is on, then
// S_LEN, then S_LFSR (one pass per lfsr clock) and S_TAIL while the voice runs, then S_OUT
// flow: one beat in flight, the next is taken once the sequencer is back in S_IDLE;
// a result still waiting on the output holds the sequencer in S_OUT
// reset: rst_n clears all but the payload registers, length_load to 8388608
// ----------------------------------------------------------------------------
// lfsr_noise_channel
// Noise voice: volume envelope, length counter and 15-bit lfsr clocked by
// a programmable period, run as a small sequencer around one subtractor.
// ----------------------------------------------------------------------------
module lfsr_noise_channel
#(
    parameter int MAX_ELAPSED = 255
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lnc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lnc_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // elapsed_cycles[7:0], length_enable
    input  logic [0:0]                       s_axis_tuser,  // cmd

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata   // sample[3:0], active
);

    lnc_pkg::state_t state_reg, state_next;

    logic [3:0]  start_volume_reg, start_volume_next;
    logic        envelope_up_reg, envelope_up_next;
    logic [2:0]  envelope_period_reg, envelope_period_next;
    logic [3:0]  clock_shift_reg, clock_shift_next;
    logic        narrow_mode_reg, narrow_mode_next;
    logic [2:0]  divisor_code_reg, divisor_code_next;
    logic        power_on_reg, power_on_next;
    logic [23:0] length_load_reg, length_load_next;

    logic [14:0] shift_reg_reg, shift_reg_next;
    logic [21:0] period_timer_reg, period_timer_next;
    logic [17:0] env_timer_reg, env_timer_next;
    logic [3:0]  volume_reg, volume_next;
    logic [23:0] length_left_reg, length_left_next;
    logic        length_on_reg, length_on_next;
    logic        triggered_reg, triggered_next;
    logic [7:0]  hz_reg, hz_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_sample_reg, out_sample_next;
    logic        out_active_reg, out_active_next;

    logic [lnc_pkg::OP_W-1:0] op_a, op_b;
    lnc_pkg::sub_res_t        sub_res;

    logic [21:0] reload;
    logic [17:0] env_per;
    logic [14:0] lfsr_step;
    logic        feedback;
    logic [7:0]  elapsed;
    logic [7:0]  hz_clamped;
    logic        in_beat;
    logic        cfg_beat;
    logic        running;
    logic [23:0] len_new;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == lnc_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_active_reg, out_sample_reg};

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign cfg_beat = cfg_valid && cfg_ready;
    assign running  = power_on_reg && triggered_reg;
    assign elapsed  = s_axis_tdata[7:0];

    assign hz_clamped = ({8'd0, elapsed} > 16'(MAX_ELAPSED)) ? 8'(MAX_ELAPSED) : elapsed;

    assign reload  = 22'(lnc_pkg::divisor(divisor_code_reg)) << clock_shift_reg;
    assign env_per = {envelope_period_reg, 15'd0};

    assign feedback = shift_reg_reg[0] ^ shift_reg_reg[1];
    always_comb
    begin
        lfsr_step = {feedback, shift_reg_reg[14:1]};
        if (narrow_mode_reg)
        begin
            lfsr_step[6] = feedback;
        end
    end

    // operand select for the shared subtractor
    always_comb
    begin
        case (state_reg)
            lnc_pkg::S_ENV_LOOP:
            begin
                op_a = {6'd0, env_timer_reg};
                op_b = {6'd0, env_per};
            end
            lnc_pkg::S_LEN:
            begin
                op_a = length_left_reg;
                op_b = {16'd0, hz_reg};
            end
            lnc_pkg::S_LFSR:
            begin
                op_a = {16'd0, hz_reg};
                op_b = {2'd0, period_timer_reg};
            end
            lnc_pkg::S_TAIL:
            begin
                op_a = {2'd0, period_timer_reg};
                op_b = {16'd0, hz_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    lnc_sub u_sub
    (
        .a   (op_a),
        .b   (op_b),
        .res (sub_res)
    );

    assign len_new = (sub_res.borrow || sub_res.zero) ? 24'd0 : sub_res.diff;

    always_comb
    begin
        state_next           = state_reg;
        start_volume_next    = start_volume_reg;
        envelope_up_next     = envelope_up_reg;
        envelope_period_next = envelope_period_reg;
        clock_shift_next     = clock_shift_reg;
        narrow_mode_next     = narrow_mode_reg;
        divisor_code_next    = divisor_code_reg;
        power_on_next        = power_on_reg;
        length_load_next     = length_load_reg;
        shift_reg_next       = shift_reg_reg;
        period_timer_next    = period_timer_reg;
        env_timer_next       = env_timer_reg;
        volume_next          = volume_reg;
        length_left_next     = length_left_reg;
        length_on_next       = length_on_reg;
        triggered_next       = triggered_reg;
        hz_next              = hz_reg;
        out_valid_next       = out_valid_reg;
        out_sample_next      = out_sample_reg;
        out_active_next      = out_active_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lnc_pkg::S_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_axis_tuser[0])
                    begin
                        period_timer_next = reload;
                        if (length_left_reg == 24'd0)
                        begin
                            length_left_next = length_load_reg;
                        end
                        shift_reg_next = lnc_pkg::LFSR_SEED;
                        length_on_next = s_axis_tdata[8];
                        volume_next    = start_volume_reg;
                        env_timer_next = 18'd0;
                        triggered_next = 1'b1;
                        // dac off leaves the voice silent
                        if (start_volume_reg == 4'd0 && !envelope_up_reg)
                        begin
                            period_timer_next = 22'd0;
                            volume_next       = 4'd0;
                            triggered_next    = 1'b0;
                        end
                        state_next = lnc_pkg::S_OUT;
                    end
                    else
                    begin
                        hz_next    = hz_clamped;
                        state_next = (envelope_period_reg != 3'd0) ? lnc_pkg::S_ENV_ADD
                                                                   : lnc_pkg::S_LEN;
                    end
                end
            end
            lnc_pkg::S_ENV_ADD:
            begin
                env_timer_next = env_timer_reg + {10'd0, hz_reg};
                state_next     = lnc_pkg::S_ENV_LOOP;
            end
            lnc_pkg::S_ENV_LOOP:
            begin
                // step while the timer is strictly above the period
                if (!sub_res.borrow && !sub_res.zero)
                begin
                    env_timer_next = sub_res.diff[17:0];
                    if (envelope_up_reg)
                    begin
                        if (volume_reg != lnc_pkg::VOLUME_MAX)
                        begin
                            volume_next = volume_reg + 4'd1;
                        end
                    end
                    else if (volume_reg != 4'd0)
                    begin
                        volume_next = volume_reg - 4'd1;
                    end
                end
                else
                begin
                    state_next = lnc_pkg::S_LEN;
                end
            end
            lnc_pkg::S_LEN:
            begin
                if (length_on_reg)
                begin
                    length_left_next = len_new;
                    if (len_new == 24'd0)
                    begin
                        volume_next = 4'd0;
                    end
                end
                state_next = running ? lnc_pkg::S_LFSR : lnc_pkg::S_OUT;
            end
            lnc_pkg::S_LFSR:
            begin
                if (!sub_res.borrow)
                begin
                    shift_reg_next    = lfsr_step;
                    hz_next           = sub_res.diff[7:0];
                    period_timer_next = reload;
                end
                else
                begin
                    state_next = lnc_pkg::S_TAIL;
                end
            end
            lnc_pkg::S_TAIL:
            begin
                period_timer_next = sub_res.diff[21:0];
                state_next        = lnc_pkg::S_OUT;
            end
            lnc_pkg::S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_active_next = running;
                    out_sample_next = (running && !shift_reg_reg[0]) ? volume_reg : 4'd0;
                    state_next      = lnc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lnc_pkg::S_IDLE;
            end
        endcase

        if (cfg_beat)
        begin
            case (cfg_index)
                lnc_pkg::CFG_START_VOLUME:    start_volume_next    = cfg_data[3:0];
                lnc_pkg::CFG_ENVELOPE_UP:     envelope_up_next     = cfg_data[0];
                lnc_pkg::CFG_ENVELOPE_PERIOD: envelope_period_next = cfg_data[2:0];
                lnc_pkg::CFG_CLOCK_SHIFT:     clock_shift_next     = cfg_data[3:0];
                lnc_pkg::CFG_NARROW_MODE:     narrow_mode_next     = cfg_data[0];
                lnc_pkg::CFG_DIVISOR_CODE:    divisor_code_next    = cfg_data[2:0];
                lnc_pkg::CFG_POWER_ON:
                begin
                    power_on_next = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        shift_reg_next    = 15'd0;
                        period_timer_next = 22'd0;
                        volume_next       = 4'd0;
                        length_left_next  = 24'd0;
                        triggered_next    = 1'b0;
                    end
                end
                lnc_pkg::CFG_LENGTH_LOAD:     length_load_next     = cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= lnc_pkg::S_IDLE;
            start_volume_reg    <= 4'd0;
            envelope_up_reg     <= 1'b0;
            envelope_period_reg <= 3'd0;
            clock_shift_reg     <= 4'd0;
            narrow_mode_reg     <= 1'b0;
            divisor_code_reg    <= 3'd0;
            power_on_reg        <= 1'b0;
            length_load_reg     <= lnc_pkg::LENGTH_LOAD_INIT;
            shift_reg_reg       <= 15'd0;
            period_timer_reg    <= 22'd0;
            env_timer_reg       <= 18'd0;
            volume_reg          <= 4'd0;
            length_left_reg     <= 24'd0;
            length_on_reg       <= 1'b0;
            triggered_reg       <= 1'b0;
            hz_reg              <= 8'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            start_volume_reg    <= start_volume_next;
            envelope_up_reg     <= envelope_up_next;
            envelope_period_reg <= envelope_period_next;
            clock_shift_reg     <= clock_shift_next;
            narrow_mode_reg     <= narrow_mode_next;
            divisor_code_reg    <= divisor_code_next;
            power_on_reg        <= power_on_next;
            length_load_reg     <= length_load_next;
            shift_reg_reg       <= shift_reg_next;
            period_timer_reg    <= period_timer_next;
            env_timer_reg       <= env_timer_next;
            volume_reg          <= volume_next;
            length_left_reg     <= length_left_next;
            length_on_reg       <= length_on_next;
            triggered_reg       <= triggered_next;
            hz_reg              <= hz_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        out_active_reg <= out_active_next;
    end

    // a trigger beat goes straight to result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_axis_tuser[0]) |=> (state_reg == lnc_pkg::S_OUT))
        else $error("trigger did not go to result state");

    // the working cycle count never exceeds the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lnc_pkg::S_IDLE) |-> ({8'd0, hz_reg} <= 16'(MAX_ELAPSED)))
        else $error("elapsed count above clamp");

    // an lfsr clock always reloads a nonzero period, so the loop ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lnc_pkg::S_LFSR && !sub_res.borrow) |=> (period_timer_reg != 22'd0))
        else $error("lfsr period reloaded with zero");

    // leaving the envelope loop leaves the timer at or below the period
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lnc_pkg::S_LEN && $past(state_reg) == lnc_pkg::S_ENV_LOOP)
        |-> (env_timer_reg <= env_per))
        else $error("envelope timer left above period");

endmodule

// File: tb/lfsr_noise_channel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr_noise_channel_tb
// Drives trigger and advance beats into the noise voice under a series of
// register settings, predicts every sample and checks it on the output stream.
// ----------------------------------------------------------------------------
module lfsr_noise_channel_tb;

    localparam int CLK_HALF_NS     = 6;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 64;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ELAPSED_CLAMP   = 255;
    localparam int ENV_STEP_CYCLES = 32768;
    // one past the last register, must be ignored
    localparam logic [lnc_pkg::CFG_IDX_W-1:0] CFG_NONE = 8'd8;

    typedef enum bit
    {
        CMD_ADVANCE = 1'b0,
        CMD_TRIGGER = 1'b1
    } noise_cmd_t;

    typedef struct packed
    {
        logic [3:0] sample;
        logic       active;
    } noise_out_t;

    class noise_voice_scoreboard;
        logic [3:0]  start_volume;
        logic        envelope_up;
        logic [2:0]  envelope_period;
        logic [3:0]  clock_shift;
        logic        narrow_mode;
        logic [2:0]  divisor_code;
        logic        power_on;
        logic [23:0] length_load;

        logic [14:0] lfsr;
        int unsigned period_left;
        int unsigned env_count;
        logic [3:0]  volume;
        int unsigned length_left;
        logic        length_on;
        logic        running;

        noise_out_t  expected_samples[$];
        int errors;
        int beats;
        int triggers;
        int results;
        int lfsr_clocks;
        int env_steps;
        int muted_advances;

        function new();
            start_volume    = '0;
            envelope_up     = 1'b0;
            envelope_period = '0;
            clock_shift     = '0;
            narrow_mode     = 1'b0;
            divisor_code    = '0;
            power_on        = 1'b0;
            length_load     = lnc_pkg::LENGTH_LOAD_INIT;
            lfsr            = '0;
            period_left     = 0;
            env_count       = 0;
            volume          = '0;
            length_left     = 0;
            length_on       = 1'b0;
            running         = 1'b0;
            errors          = 0;
            beats           = 0;
            triggers        = 0;
            results         = 0;
            lfsr_clocks     = 0;
            env_steps       = 0;
            muted_advances  = 0;
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction

        // divisor is 8 for code 0, otherwise 16 per code step
        function int unsigned period_reload();
            int unsigned base;
            base = (divisor_code == 3'd0) ? 8 : 16 * divisor_code;
            return base << clock_shift;
        endfunction

        function void clock_lfsr();
            logic fb;
            fb   = lfsr[0] ^ lfsr[1];
            lfsr = {fb, lfsr[14:1]};
            if (narrow_mode)
                lfsr[6] = fb;
            lfsr_clocks++;
        endfunction

        function void write_reg(logic [lnc_pkg::CFG_IDX_W-1:0] idx,
                                logic [lnc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lnc_pkg::CFG_START_VOLUME:    start_volume    = data[3:0];
                lnc_pkg::CFG_ENVELOPE_UP:     envelope_up     = data[0];
                lnc_pkg::CFG_ENVELOPE_PERIOD: envelope_period = data[2:0];
                lnc_pkg::CFG_CLOCK_SHIFT:     clock_shift     = data[3:0];
                lnc_pkg::CFG_NARROW_MODE:     narrow_mode     = data[0];
                lnc_pkg::CFG_DIVISOR_CODE:    divisor_code    = data[2:0];
                lnc_pkg::CFG_POWER_ON:
                begin
                    power_on = data[0];
                    if (!power_on)
                    begin
                        lfsr        = '0;
                        period_left = 0;
                        volume      = '0;
                        length_left = 0;
                        running     = 1'b0;
                    end
                end
                lnc_pkg::CFG_LENGTH_LOAD:     length_load     = data;
                default: ;
            endcase
        endfunction

        function void take_beat(noise_cmd_t cmd, logic [7:0] elapsed, logic len_en);
            int unsigned cycles;
            int unsigned env_span;
            noise_out_t  res;
            beats++;
            if (cmd == CMD_TRIGGER)
            begin
                triggers++;
                period_left = period_reload();
                if (length_left == 0)
                    length_left = length_load;
                lfsr      = lnc_pkg::LFSR_SEED;
                length_on = len_en;
                volume    = start_volume;
                env_count = 0;
                running   = 1'b1;
                // dac off: voice stays silent
                if (start_volume == 4'd0 && !envelope_up)
                begin
                    period_left = 0;
                    volume      = '0;
                    running     = 1'b0;
                end
            end
            else
            begin
                cycles = (elapsed > ELAPSED_CLAMP) ? ELAPSED_CLAMP : elapsed;
                if (envelope_period != 3'd0)
                begin
                    env_span  = ENV_STEP_CYCLES * envelope_period;
                    env_count += cycles;
                    while (env_count > env_span)
                    begin
                        if (envelope_up)
                        begin
                            if (volume != lnc_pkg::VOLUME_MAX)
                                volume++;
                        end
                        else if (volume != 4'd0)
                        begin
                            volume--;
                        end
                        env_count -= env_span;
                        env_steps++;
                    end
                    env_count &= 32'h3FFFF;
                end
                if (length_on)
                begin
                    length_left = (length_left > cycles) ? length_left - cycles : 0;
                    if (length_left == 0)
                    begin
                        volume = '0;
                        muted_advances++;
                    end
                end
                if (power_on && running)
                begin
                    while (cycles >= period_left)
                    begin
                        clock_lfsr();
                        cycles      -= period_left;
                        period_left  = period_reload();
                    end
                    period_left -= cycles;
                end
            end
            res.active = power_on && running;
            res.sample = (res.active && !lfsr[0]) ? volume : 4'd0;
            expected_samples.push_back(res);
        endfunction

        function void check_result(logic [3:0] sample, logic active);
            noise_out_t want;
            results++;
            if (expected_samples.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, sample=%0d active=%0d",
                         $time, sample, active);
                return;
            end
            want = expected_samples.pop_front();
            if (sample !== want.sample)
            begin
                errors++;
                $display("%0t: sample mismatch, expected %0d actual %0d",
                         $time, want.sample, sample);
            end
            if (active !== want.active)
            begin
                errors++;
                $display("%0t: active mismatch, expected %0d actual %0d",
                         $time, want.active, active);
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lnc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lnc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata;   // elapsed_cycles[7:0], length_enable
    logic [0:0]                     s_axis_tuser;   // cmd
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [7:0]                     m_axis_tdata;   // sample[3:0], active

    noise_voice_scoreboard sb;
    int cycle_count = 0;
    bit gap_en;
    bit stall_en;

    lfsr_noise_channel
    #(
        .MAX_ELAPSED (ELAPSED_CLAMP)
    )
    dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #(CLK_HALF_NS) clk = 1'b1;
        #(CLK_HALF_NS) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d samples outstanding",
                     $time, cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[3:0], m_axis_tdata[4]);
    end

    // output back-pressure in random bursts
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(input noise_cmd_t cmd, input logic [7:0] elapsed,
                             input logic len_en);
        if (gap_en && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, len_en, elapsed};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.take_beat(cmd, elapsed, len_en);
    endtask

    task automatic write_reg(input logic [lnc_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[lnc_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, value[lnc_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic program_voice(input int unsigned vol, input int unsigned up,
                                 input int unsigned env_per, input int unsigned shift,
                                 input int unsigned narrow, input int unsigned div,
                                 input int unsigned power, input int unsigned len);
        write_reg(lnc_pkg::CFG_START_VOLUME, vol);
        write_reg(lnc_pkg::CFG_ENVELOPE_UP, up);
        write_reg(lnc_pkg::CFG_ENVELOPE_PERIOD, env_per);
        write_reg(lnc_pkg::CFG_CLOCK_SHIFT, shift);
        write_reg(lnc_pkg::CFG_NARROW_MODE, narrow);
        write_reg(lnc_pkg::CFG_DIVISOR_CODE, div);
        write_reg(lnc_pkg::CFG_POWER_ON, power);
        write_reg(lnc_pkg::CFG_LENGTH_LOAD, len);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending, let every sample come back, then give the block time to go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int n_items, input bit env_heavy);
        noise_cmd_t  cmd;
        logic [7:0]  elapsed;
        for (int i = 0; i < n_items; i++)
        begin
            if (env_heavy)
            begin
                // long runs of full advances so the envelope gets to step
                cmd     = ($urandom_range(0, 119) == 0) ? CMD_TRIGGER : CMD_ADVANCE;
                elapsed = ($urandom_range(0, 3) != 0) ? 8'd255 : 8'($urandom_range(0, 255));
            end
            else
            begin
                cmd = ($urandom_range(0, 5) == 0) ? CMD_TRIGGER : CMD_ADVANCE;
                case ($urandom_range(0, 7))
                    0:       elapsed = 8'd0;
                    1:       elapsed = 8'd255;
                    default: elapsed = 8'($urandom_range(0, 255));
                endcase
            end
            send_beat(cmd, elapsed, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        gap_en   = 1'b1;
        stall_en = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unpowered after reset: trigger is taken, nothing is heard
        send_beat(CMD_TRIGGER, 8'd0, 1'b1);
        send_beat(CMD_ADVANCE, 8'd255, 1'b0);
        settle();

        write_reg(CFG_NONE, 24'hFFFFFF);
        program_voice(15, 0, 0, 0, 0, 0, 0, 300);
        program_voice(15, 0, 0, 0, 0, 0, 1, 300);
        // length runs out after two full advances and mutes the voice
        send_beat(CMD_TRIGGER, 8'd0, 1'b1);
        send_beat(CMD_ADVANCE, 8'd0, 1'b0);
        send_beat(CMD_ADVANCE, 8'd1, 1'b0);
        send_beat(CMD_ADVANCE, 8'd7, 1'b0);
        send_beat(CMD_ADVANCE, 8'd8, 1'b0);
        send_beat(CMD_ADVANCE, 8'd255, 1'b0);
        send_beat(CMD_ADVANCE, 8'd255, 1'b0);
        send_beat(CMD_ADVANCE, 8'd128, 1'b1);
        send_beat(CMD_TRIGGER, 8'd255, 1'b0);
        send_beat(CMD_ADVANCE, 8'd255, 1'b1);
        send_beat(CMD_ADVANCE, 8'd170, 1'b0);
        send_beat(CMD_ADVANCE, 8'd85, 1'b1);
        settle();

        program_voice(9, 1, 0, 0, 1, 7, 1, 300);
        send_beat(CMD_TRIGGER, 8'd0, 1'b0);
        send_beat(CMD_ADVANCE, 8'd255, 1'b0);
        send_beat(CMD_ADVANCE, 8'd200, 1'b0);
        send_beat(CMD_ADVANCE, 8'd255, 1'b0);
        settle();

        // dac off at trigger
        program_voice(0, 0, 7, 2, 0, 3, 1, 300);
        send_beat(CMD_TRIGGER, 8'd0, 1'b0);
        send_beat(CMD_ADVANCE, 8'd255, 1'b0);
        settle();

        // trigger while unpowered, then power comes back
        program_voice(5, 1, 7, 2, 0, 3, 0, 300);
        send_beat(CMD_TRIGGER, 8'd0, 1'b1);
        send_beat(CMD_ADVANCE, 8'd100, 1'b0);
        settle();
        program_voice(5, 1, 7, 2, 0, 3, 1, 300);
        send_beat(CMD_ADVANCE, 8'd255, 1'b0);
        send_beat(CMD_ADVANCE, 8'd255, 1'b1);
        settle();

        program_voice(15, 1, 7, 15, 1, 7, 1, 24'hFFFFFF);
        random_phase(30, 1'b0);
        settle();

        gap_en = 1'b0;
        program_voice(0, 0, 0, 0, 0, 0, 1, 0);
        random_phase(30, 1'b0);
        settle();

        gap_en = 1'b1;
        program_voice($urandom_range(1, 14), $urandom_range(0, 1), 1, 0,
                      $urandom_range(0, 1), $urandom_range(0, 7), 1, 24'hFFFFFF);
        random_phase(220, 1'b1);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            gap_en   = (p % 2 == 0);
            stall_en = (p != 1);
            program_voice($urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 7),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 2),
                          $urandom_range(0, 1), $urandom_range(0, 7),
                          ($urandom_range(0, 5) != 0),
                          ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 3000));
            random_phase(25, 1'b0);
            settle();
        end

        // closing stretch runs at full rate on both sides
        gap_en   = 1'b0;
        stall_en = 1'b0;
        program_voice($urandom_range(1, 15), $urandom_range(0, 1), $urandom_range(1, 7),
                      $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 7),
                      1, $urandom_range(200, 2000));
        random_phase(30, 1'b0);
        settle();

        $display("covered %0d beats (%0d triggers) and %0d result beats",
                 sb.beats, sb.triggers, sb.results);
        $display("lfsr clocks %0d, envelope steps %0d, advances under a muted length %0d",
                 sb.lfsr_clocks, sb.env_steps, sb.muted_advances);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lnc_pkg.sv
rtl/core/lnc_sub.sv
rtl/core/lfsr_noise_channel.sv
tb/lfsr_noise_channel_tb.sv
